@@ rtl/tcce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine: command
// codes, control characters, register indexes and the job descriptor that
// travels from the front end to the command sequencer.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // framebuffer command codes seen on the result channel
  typedef enum logic [2:0] {
    CMD_RESTORE = 3'd0,
    CMD_DRAW    = 3'd1,
    CMD_SHOW    = 3'd2,
    CMD_SCROLL  = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  // micro-steps that the sequencer expands into commands
  typedef enum logic [2:0] {
    U_RESTORE_CUR = 3'd0,   // restore at old cursor, blank flag from job
    U_RESTORE_NEW = 3'd1,   // restore at new cursor, saved cell present
    U_DRAW_CUR    = 3'd2,
    U_DRAW_NEW    = 3'd3,
    U_SCROLL      = 3'd4,
    U_CLEAR       = 3'd5,
    U_SHOW_NEW    = 3'd6
  } uop_t;

  // control characters
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_UP        = 8'h86;
  localparam logic [7:0] CH_DOWN      = 8'h87;
  localparam logic [7:0] CH_LEFT      = 8'h88;
  localparam logic [7:0] CH_RIGHT     = 8'h89;
  localparam logic [7:0] CH_CLEAR     = 8'h90;
  localparam logic [7:0] CH_HIDE      = 8'h91;
  localparam logic [7:0] CH_SHOW      = 8'h92;

  localparam logic [7:0]  GLYPH_CURSOR = 8'd219;
  localparam logic [7:0]  GLYPH_SPACE  = 8'd32;
  localparam logic [15:0] HOME_POS     = 16'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LR_MARGIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TB_MARGIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_GAP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_GAP       = 3'd5;

  typedef struct packed {
    logic [15:0] screen_width;
    logic [15:0] screen_height;
    logic [7:0]  lr_margin;
    logic [7:0]  tb_margin;
    logic [7:0]  column_gap;
    logic [7:0]  row_gap;
  } cfg_t;

  localparam int MAX_UOPS = 5;
  localparam int UCNT_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  // one accepted character, classified
  typedef struct packed {
    logic [UCNT_W-1:0]       n_uops;
    uop_t [MAX_UOPS-1:0]     uops;
    logic [15:0]             cur_x;
    logic [15:0]             cur_y;
    logic [15:0]             new_x;
    logic [15:0]             new_y;
    logic [7:0]              glyph;
    logic                    blank;
  } desc_t;

endpackage

@@ rtl/tcce_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_front
// Accepts characters, owns the cursor state and turns each character into
// a job descriptor listing the commands to issue.
// ----------------------------------------------------------------------------
module tcce_front #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tcce_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_char_code,
  output logic           push_valid,
  input  logic           push_ready,
  output tcce_pkg::desc_t push_desc
);
  import tcce_pkg::*;

  // width of gap plus two glyph extents
  localparam int GLYPH_MAX = (GLYPH_WIDTH > GLYPH_HEIGHT) ? GLYPH_WIDTH : GLYPH_HEIGHT;
  localparam int OFS_W = $clog2(255 + 2 * GLYPH_MAX + 1);

  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic        sv_r,  sv_nxt;

  logic [15:0]      line_v, cell_v;
  logic [OFS_W-1:0] down_ofs, right_ofs;
  logic [16:0]      down_lhs, right_lhs;
  logic [15:0]      down_lim, right_lim;
  logic             bottom_blk, right_blk;
  logic             at_left, at_top;
  desc_t            d;
  logic             fire;

  assign in_ready = push_ready;
  assign fire     = in_valid && in_ready;

  // edge tests, a resolution below its margin never blocks
  always_comb begin
    line_v    = 16'(cfg.row_gap) + 16'(GLYPH_HEIGHT);
    cell_v    = 16'(cfg.column_gap) + 16'(GLYPH_WIDTH);
    down_ofs  = OFS_W'(cfg.row_gap) + OFS_W'(2 * GLYPH_HEIGHT);
    right_ofs = OFS_W'(cfg.column_gap) + OFS_W'(2 * GLYPH_WIDTH);
    down_lhs  = 17'(row_r) + 17'(down_ofs);
    right_lhs = 17'(col_r) + 17'(right_ofs);
    down_lim  = cfg.screen_height - 16'(cfg.tb_margin);
    right_lim = cfg.screen_width - 16'(cfg.lr_margin);
    bottom_blk = (cfg.screen_height >= 16'(cfg.tb_margin)) && (down_lhs > {1'b0, down_lim});
    right_blk  = (cfg.screen_width >= 16'(cfg.lr_margin)) && (right_lhs > {1'b0, right_lim});
    at_left    = (col_r == 16'(cfg.lr_margin));
    at_top     = (row_r == 16'(cfg.tb_margin));
  end

  always_comb begin
    d        = '0;
    d.cur_x  = col_r;
    d.cur_y  = row_r;
    d.new_x  = col_r;
    d.new_y  = row_r;
    d.glyph  = in_char_code;
    d.blank  = !sv_r;
    d.n_uops = '0;
    unique case (in_char_code)
      CH_NEWLINE: begin
        d.new_x = 16'(cfg.lr_margin);
        if (bottom_blk) begin
          d.uops[1] = U_SCROLL;
          d.uops[2] = U_SHOW_NEW;
          d.n_uops  = 3'd3;
        end else begin
          d.new_y   = row_r + line_v;
          d.uops[1] = U_SHOW_NEW;
          d.n_uops  = 3'd2;
        end
      end
      CH_BACKSPACE: begin
        d.glyph = GLYPH_SPACE;
        if (!at_left) begin
          d.new_x   = col_r - cell_v;
          d.uops[1] = U_SHOW_NEW;
          d.uops[2] = U_RESTORE_NEW;
          d.uops[3] = U_DRAW_NEW;
          d.uops[4] = U_SHOW_NEW;
          d.n_uops  = 3'd5;
        end else begin
          d.uops[1] = U_DRAW_NEW;
          d.uops[2] = U_SHOW_NEW;
          d.n_uops  = 3'd3;
        end
      end
      CH_UP: begin
        if (!at_top) begin
          d.new_y   = row_r - line_v;
          d.uops[1] = U_SHOW_NEW;
          d.n_uops  = 3'd2;
        end
      end
      CH_DOWN: begin
        if (!bottom_blk) begin
          d.new_y   = row_r + line_v;
          d.uops[1] = U_SHOW_NEW;
          d.n_uops  = 3'd2;
        end
      end
      CH_LEFT: begin
        if (!at_left) begin
          d.new_x   = col_r - cell_v;
          d.uops[1] = U_SHOW_NEW;
          d.n_uops  = 3'd2;
        end
      end
      CH_RIGHT: begin
        if (!right_blk) begin
          d.new_x   = col_r + cell_v;
          d.uops[1] = U_SHOW_NEW;
          d.n_uops  = 3'd2;
        end
      end
      CH_CLEAR: begin
        d.new_x   = HOME_POS;
        d.new_y   = HOME_POS;
        d.uops[1] = U_CLEAR;
        d.uops[2] = U_SHOW_NEW;
        d.n_uops  = 3'd3;
      end
      CH_HIDE: begin
        d.n_uops = 3'd1;
      end
      CH_SHOW: begin
        d.uops[0] = U_SHOW_NEW;
        d.n_uops  = 3'd1;
      end
      default: begin
        // printable byte
        d.uops[1] = U_DRAW_CUR;
        if (bottom_blk && right_blk) begin
          d.new_x   = 16'(cfg.lr_margin);
          d.uops[2] = U_SCROLL;
          d.uops[3] = U_SHOW_NEW;
          d.n_uops  = 3'd4;
        end else if (right_blk) begin
          d.new_x   = 16'(cfg.lr_margin);
          d.new_y   = row_r + line_v;
          d.uops[2] = U_SHOW_NEW;
          d.n_uops  = 3'd3;
        end else begin
          d.new_x   = col_r + cell_v;
          d.uops[2] = U_SHOW_NEW;
          d.n_uops  = 3'd3;
        end
      end
    endcase
  end

  assign push_desc  = d;
  assign push_valid = in_valid && (d.n_uops != '0);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    sv_nxt  = sv_r;
    if (fire && (d.n_uops != '0)) begin
      col_nxt = d.new_x;
      row_nxt = d.new_y;
      sv_nxt  = (in_char_code != CH_HIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= HOME_POS;
      row_r <= HOME_POS;
      sv_r  <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      sv_r  <= sv_nxt;
    end
  end

endmodule

@@ rtl/tcce_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_queue
// Short flop-based queue of job descriptors between front end and
// sequencer.
// ----------------------------------------------------------------------------
module tcce_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  tcce_pkg::desc_t push_desc,
  output logic            pop_valid,
  input  logic            pop_ready,
  output tcce_pkg::desc_t pop_desc
);
  import tcce_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  desc_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_desc   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

@@ rtl/tcce_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_back
// Command sequencer: walks the steps of the job at the queue head and
// issues one registered command per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module tcce_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_done,
  input  tcce_pkg::desc_t job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [2:0]      out_command,
  output logic [15:0]     out_pos_x,
  output logic [15:0]     out_pos_y,
  output logic [7:0]      out_glyph,
  output logic            out_restore_blank,
  output logic            out_last
);
  import tcce_pkg::*;

  logic [UCNT_W-1:0] idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  cmd_t              cmd_r, cmd_v;
  logic [15:0]       x_r, x_v;
  logic [15:0]       y_r, y_v;
  logic [7:0]        g_r, g_v;
  logic              blank_r, blank_v;
  logic              last_r, last_v;
  logic              adv;

  assign adv      = job_valid && (!valid_r || out_ready);
  assign last_v   = (idx_r == job.n_uops - 1'b1);
  assign job_done = adv && last_v;

  // step decoder
  always_comb begin
    cmd_v   = CMD_RESTORE;
    x_v     = '0;
    y_v     = '0;
    g_v     = '0;
    blank_v = 1'b0;
    unique case (job.uops[idx_r])
      U_RESTORE_CUR: begin
        x_v     = job.cur_x;
        y_v     = job.cur_y;
        blank_v = job.blank;
      end
      U_RESTORE_NEW: begin
        x_v = job.new_x;
        y_v = job.new_y;
      end
      U_DRAW_CUR: begin
        cmd_v = CMD_DRAW;
        x_v   = job.cur_x;
        y_v   = job.cur_y;
        g_v   = job.glyph;
      end
      U_DRAW_NEW: begin
        cmd_v = CMD_DRAW;
        x_v   = job.new_x;
        y_v   = job.new_y;
        g_v   = job.glyph;
      end
      U_SCROLL: begin
        cmd_v = CMD_SCROLL;
        y_v   = job.cur_y;
      end
      U_CLEAR: begin
        cmd_v = CMD_CLEAR;
      end
      U_SHOW_NEW: begin
        cmd_v = CMD_SHOW;
        x_v   = job.new_x;
        y_v   = job.new_y;
        g_v   = GLYPH_CURSOR;
      end
      default: begin
        cmd_v = CMD_RESTORE;
      end
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = 1'b1;
      idx_nxt   = last_v ? '0 : idx_r + 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r   <= cmd_v;
      x_r     <= x_v;
      y_r     <= y_v;
      g_r     <= g_v;
      blank_r <= blank_v;
      last_r  <= last_v;
    end
  end

  assign out_valid         = valid_r;
  assign out_command       = cmd_r;
  assign out_pos_x         = x_r;
  assign out_pos_y         = y_r;
  assign out_glyph         = g_r;
  assign out_restore_blank = blank_r;
  assign out_last          = last_r;

endmodule

@@ rtl/text_console_cursor_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Character-to-framebuffer-command engine for a text console.
// ----------------------------------------------------------------------------
// Each accepted character byte becomes one to five framebuffer commands
// (restore cell, draw glyph, save cell and show cursor, scroll up, clear
// screen) with the final one flagged by out_last; blocked cursor moves
// give no commands at all. The front end takes a character every cycle
// while its two-entry job queue has room, updating the cursor position and
// saved-cell flag at once, so the next character sees the new cursor. The
// sequencer issues one command per cycle from the job at the queue head
// while the renderer takes them. A character has one to five commands,
// three or four when printable; the sustained rate is set by the sequencer and
// by how fast the renderer takes commands. Configuration writes take effect
// on the next edge and should only be made while the engine is idle.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata,
  // character input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_char_code,
  // command output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_command,
  output logic [15:0]                    out_pos_x,
  output logic [15:0]                    out_pos_y,
  output logic [7:0]                     out_glyph,
  output logic                           out_restore_blank,
  output logic                           out_last
);
  import tcce_pkg::*;

  cfg_t  cfg_r;
  logic  push_valid, push_ready;
  desc_t push_desc;
  logic  job_valid, job_done;
  desc_t job;

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= 16'd640;
      cfg_r.screen_height <= 16'd480;
      cfg_r.lr_margin     <= 8'd4;
      cfg_r.tb_margin     <= 8'd4;
      cfg_r.column_gap    <= 8'd2;
      cfg_r.row_gap       <= 8'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_wdata;
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_wdata;
        REG_LR_MARGIN:     cfg_r.lr_margin     <= cfg_wdata[7:0];
        REG_TB_MARGIN:     cfg_r.tb_margin     <= cfg_wdata[7:0];
        REG_COLUMN_GAP:    cfg_r.column_gap    <= cfg_wdata[7:0];
        REG_ROW_GAP:       cfg_r.row_gap       <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // classify characters and track the cursor
  tcce_front #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_desc    (push_desc)
  );

  // jobs waiting for the sequencer
  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (job_valid),
    .pop_ready  (job_done),
    .pop_desc   (job)
  );

  // expand the head job into commands, one transfer per cycle unless stalled
  tcce_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (job_valid),
    .job_done          (job_done),
    .job               (job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command       (out_command),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_glyph         (out_glyph),
    .out_restore_blank (out_restore_blank),
    .out_last          (out_last)
  );

endmodule

@@ rtl/tcce_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the cursor engine's command stream.
// ----------------------------------------------------------------------------
module tcce_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [2:0]                     out_command,
  input  logic [15:0]                    out_pos_x,
  input  logic [15:0]                    out_pos_y,
  input  logic [7:0]                     out_glyph,
  input  logic                           out_restore_blank,
  input  logic                           out_last
);
  import tcce_pkg::*;

  // a stalled command holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command) &&
      $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_glyph) &&
      $stable(out_last))
    else $error("stalled command changed");

  // blank flag only on restore
  a_blank_restore: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command != CMD_RESTORE) |-> !out_restore_blank)
    else $error("restore_blank set on non-restore command");

  // scroll and clear are never last and carry zero x position and glyph
  a_scroll_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_command == CMD_SCROLL) || (out_command == CMD_CLEAR)) |->
      !out_last && (out_pos_x == 16'd0) && (out_glyph == 8'd0))
    else $error("bad scroll or clear command");

  // a character ends with the cursor shown or hidden
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |->
      ((out_command == CMD_SHOW) || (out_command == CMD_RESTORE)))
    else $error("last command neither show nor restore");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the text console cursor engine.
// ----------------------------------------------------------------------------
// A directed table first covers hide, show, blocked moves, byte extremes,
// every control code, backspace at the margin, line wrap and scroll on a
// small screen. Random characters then run under several screen geometries,
// among them the largest values, resolutions below their margins and
// position wrap. A mirror of the cursor state predicts the framebuffer
// commands of every accepted character, and each command that leaves the
// engine is checked field by field against the oldest prediction. Both
// channels stall at random, and once the command side holds off for a long
// stretch so that the engine fills up and stalls its character input.
// ----------------------------------------------------------------------------
module tb;
  import tcce_pkg::*;

  localparam int GLYPH_W     = 8;
  localparam int GLYPH_H     = 16;
  localparam int SETTLE      = 20;         // cycles for a command-free character to retire
  localparam int HOLD_CYCLES = 300;        // long command-side hold-off
  localparam int PHASE_CHARS = 44;         // productive characters per random phase
  localparam int N_PHASES    = 7;
  localparam longint TIMEOUT_NS = 5_000_000;

  // one framebuffer command as it appears on the output channel
  typedef struct packed {
    cmd_t        command;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  glyph;
    logic        blank;
    logic        last;
  } fb_cmd_t;

  // one row of the directed table
  typedef struct packed {
    logic       retune;   // drain, then switch to the small screen
    logic [7:0] code;
    logic       typed;    // expected commands are typed into the table
    logic [2:0] n;        // how many typed commands belong to this row
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_WIDTH;
  logic [15:0]          cfg_wdata = 16'd0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_code = 8'd0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_command;
  logic [15:0] out_pos_x;
  logic [15:0] out_pos_y;
  logic [7:0]  out_glyph;
  logic        out_restore_blank;
  logic        out_last;

  // sideband that travels with each offered character
  logic       row_typed = 1'b0;
  logic [2:0] row_n = 3'd0;

  // idle rates in percent, written only by the stimulus process
  int tx_gap_pct = 37;
  int rx_gap_pct = 83;

  // long hold-off handshake: the stimulus bumps the request count
  int hold_reqs = 0;
  int holds_done = 0;
  int hold_left = 0;

  // predicted command stream and bookkeeping
  fb_cmd_t  cmd_expect_q[$];
  fb_cmd_t  typed_cmds[$];
  fb_cmd_t  char_cmds[$];
  dir_row_t dir_tab[$];
  int       mismatches = 0;
  int       busy_chars = 0;   // accepted characters that produced commands

  // mirror of the engine's cursor and geometry
  logic [15:0] curs_x;
  logic [15:0] curs_y;
  logic        cell_saved;
  cfg_t        geom;

  always #5 clk = ~clk;

  text_console_cursor_engine_unit #(
    .GLYPH_WIDTH  (GLYPH_W),
    .GLYPH_HEIGHT (GLYPH_H)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command       (out_command),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_glyph         (out_glyph),
    .out_restore_blank (out_restore_blank),
    .out_last          (out_last)
  );

  // --------------------------------------------------------------------------
  // cursor mirror
  // --------------------------------------------------------------------------

  function automatic cfg_t mk_cfg(input logic [15:0] w, input logic [15:0] h,
                                  input logic [7:0] lr, input logic [7:0] tb_m,
                                  input logic [7:0] cg, input logic [7:0] rg);
    cfg_t c;
    c.screen_width  = w;
    c.screen_height = h;
    c.lr_margin     = lr;
    c.tb_margin     = tb_m;
    c.column_gap    = cg;
    c.row_gap       = rg;
    return c;
  endfunction

  function automatic void add_cmd(input cmd_t c, input logic [15:0] x, input logic [15:0] y,
                                  input logic [7:0] g, input logic b);
    fb_cmd_t e;
    e.command = c;
    e.pos_x   = x;
    e.pos_y   = y;
    e.glyph   = g;
    e.blank   = b;
    e.last    = 1'b0;
    char_cmds.push_back(e);
  endfunction

  // restore the cell under the cursor, blank if nothing was saved
  function automatic void hide_cur();
    add_cmd(CMD_RESTORE, curs_x, curs_y, 8'd0, !cell_saved);
    cell_saved = 1'b0;
  endfunction

  function automatic void show_cur();
    add_cmd(CMD_SHOW, curs_x, curs_y, GLYPH_CURSOR, 1'b0);
    cell_saved = 1'b1;
  endfunction

  function automatic void place_cur(input logic [15:0] x, input logic [15:0] y);
    curs_x = x;
    curs_y = y;
    show_cur();
  endfunction

  // no room for another line below; the limit wraps when height < margin
  function automatic logic row_full();
    logic [31:0] need;
    logic [31:0] lim;
    need = {16'd0, curs_y} + 32'(2 * GLYPH_H) + {24'd0, geom.row_gap};
    lim  = {16'd0, geom.screen_height} - {24'd0, geom.tb_margin};
    return need > lim;
  endfunction

  function automatic logic col_full();
    logic [31:0] need;
    logic [31:0] lim;
    need = {16'd0, curs_x} + 32'(2 * GLYPH_W) + {24'd0, geom.column_gap};
    lim  = {16'd0, geom.screen_width} - {24'd0, geom.lr_margin};
    return need > lim;
  endfunction

  // one cell to the left, nothing at the left margin
  function automatic void back_one();
    if (curs_x == {8'd0, geom.lr_margin}) return;
    hide_cur();
    place_cur(curs_x - {8'd0, geom.column_gap} - 16'(GLYPH_W), curs_y);
  endfunction

  // commands caused by one character, left in char_cmds with last marked
  function automatic void predict_char_cmds(input logic [7:0] c);
    logic [15:0] line_px;
    logic [15:0] cell_px;
    logic [15:0] home_x;
    fb_cmd_t     t;
    line_px = {8'd0, geom.row_gap} + 16'(GLYPH_H);
    cell_px = {8'd0, geom.column_gap} + 16'(GLYPH_W);
    home_x  = {8'd0, geom.lr_margin};
    char_cmds.delete();
    case (c)
      CH_NEWLINE: begin
        hide_cur();
        if (row_full()) begin
          add_cmd(CMD_SCROLL, 16'd0, curs_y, 8'd0, 1'b0);
          place_cur(home_x, curs_y);
        end else begin
          place_cur(home_x, curs_y + line_px);
        end
      end
      CH_BACKSPACE: begin
        // the cell is blanked even when the move is blocked
        back_one();
        hide_cur();
        add_cmd(CMD_DRAW, curs_x, curs_y, GLYPH_SPACE, 1'b0);
        show_cur();
      end
      CH_UP: begin
        if (curs_y != {8'd0, geom.tb_margin}) begin
          hide_cur();
          place_cur(curs_x, curs_y - line_px);
        end
      end
      CH_DOWN: begin
        if (!row_full()) begin
          hide_cur();
          place_cur(curs_x, curs_y + line_px);
        end
      end
      CH_LEFT: back_one();
      CH_RIGHT: begin
        if (!col_full()) begin
          hide_cur();
          place_cur(curs_x + cell_px, curs_y);
        end
      end
      CH_CLEAR: begin
        hide_cur();
        add_cmd(CMD_CLEAR, 16'd0, 16'd0, 8'd0, 1'b0);
        place_cur(HOME_POS, HOME_POS);
      end
      CH_HIDE: hide_cur();
      CH_SHOW: show_cur();
      default: begin
        // printable: draw, then advance with wrap, scroll at the corner
        hide_cur();
        add_cmd(CMD_DRAW, curs_x, curs_y, c, 1'b0);
        if (row_full() && col_full()) begin
          add_cmd(CMD_SCROLL, 16'd0, curs_y, 8'd0, 1'b0);
          place_cur(home_x, curs_y);
        end else if (col_full()) begin
          place_cur(home_x, curs_y + line_px);
        end else begin
          place_cur(curs_x + cell_px, curs_y);
        end
      end
    endcase
    if (char_cmds.size() != 0) begin
      t = char_cmds.pop_back();
      t.last = 1'b1;
      char_cmds.push_back(t);
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // interface watcher: checks commands, mirrors config writes, predicts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : fb_watch
    fb_cmd_t want;
    int      k;
    if (!rst_n) begin
      geom       = mk_cfg(16'd640, 16'd480, 8'd4, 8'd4, 8'd2, 8'd4);
      curs_x     = HOME_POS;
      curs_y     = HOME_POS;
      cell_saved = 1'b0;
      cmd_expect_q.delete();
    end else begin
      // command transfer against the oldest prediction
      if (out_valid && out_ready) begin
        if (cmd_expect_q.size() == 0) begin
          $error("command %0d at (%0d,%0d) with nothing expected",
                 out_command, out_pos_x, out_pos_y);
          mismatches++;
        end else begin
          want = cmd_expect_q.pop_front();
          check_field("command", 16'(want.command), 16'(out_command));
          check_field("pos_x", want.pos_x, out_pos_x);
          check_field("pos_y", want.pos_y, out_pos_y);
          check_field("glyph", 16'(want.glyph), 16'(out_glyph));
          check_field("restore_blank", 16'(want.blank), 16'(out_restore_blank));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  geom.screen_width  = cfg_wdata;
          REG_SCREEN_HEIGHT: geom.screen_height = cfg_wdata;
          REG_LR_MARGIN:     geom.lr_margin     = cfg_wdata[7:0];
          REG_TB_MARGIN:     geom.tb_margin     = cfg_wdata[7:0];
          REG_COLUMN_GAP:    geom.column_gap    = cfg_wdata[7:0];
          REG_ROW_GAP:       geom.row_gap       = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // character transfer: the mirror always advances, typed rows
      // replace the predicted commands with the ones in the table
      if (in_valid && in_ready) begin
        predict_char_cmds(in_char_code);
        if (row_typed) begin
          for (k = 0; k < int'(row_n); k++) cmd_expect_q.push_back(typed_cmds.pop_front());
          if (row_n != 3'd0) busy_chars++;
        end else begin
          foreach (char_cmds[i]) cmd_expect_q.push_back(char_cmds[i]);
          if (char_cmds.size() != 0) busy_chars++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // command side: random stalls plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_reqs) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_gap_pct);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  task automatic add_row(input logic retune, input logic [7:0] code, input int n);
    dir_row_t r;
    r.retune = retune;
    r.code   = code;
    r.typed  = (n >= 0);
    r.n      = (n >= 0) ? 3'(n) : 3'd0;
    dir_tab.push_back(r);
  endtask

  task automatic add_exp(input cmd_t c, input logic [15:0] x, input logic [15:0] y,
                         input logic [7:0] g, input logic b, input logic l);
    fb_cmd_t e;
    e.command = c;
    e.pos_x   = x;
    e.pos_y   = y;
    e.glyph   = g;
    e.blank   = b;
    e.last    = l;
    typed_cmds.push_back(e);
  endtask

  // offer one character; valid only drops when a sender gap is taken
  task automatic send_char(input logic [7:0] code, input logic typed, input logic [2:0] n);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_gap_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    row_typed    <= typed;
    row_n        <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait until every predicted command is out and the engine has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cmd_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_SCREEN_WIDTH, c.screen_width);
    write_reg(REG_SCREEN_HEIGHT, c.screen_height);
    write_reg(REG_LR_MARGIN, {8'd0, c.lr_margin});
    write_reg(REG_TB_MARGIN, {8'd0, c.tb_margin});
    write_reg(REG_COLUMN_GAP, {8'd0, c.column_gap});
    write_reg(REG_ROW_GAP, {8'd0, c.row_gap});
    cfg_we <= 1'b0;
  endtask

  // printable bytes are the most frequent pick so the cursor travels far between clears
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(255));
    if (r < 55) return CH_NEWLINE;
    if (r < 63) return CH_BACKSPACE;
    if (r < 85) begin
      case ($urandom_range(3))
        0:       return CH_UP;
        1:       return CH_DOWN;
        2:       return CH_LEFT;
        default: return CH_RIGHT;
      endcase
    end
    if (r < 88) return CH_CLEAR;
    if (r < 94) return CH_HIDE;
    return CH_SHOW;
  endfunction

  initial begin
    cfg_t cfg_now;
    int   target;

    // directed table, reset geometry 640x480, cursor at home, nothing saved
    add_row(1'b0, CH_HIDE, 1);        // hide with nothing saved: blank restore
    add_exp(CMD_RESTORE, HOME_POS, HOME_POS, 8'd0, 1'b1, 1'b1);
    add_row(1'b0, CH_SHOW, 1);
    add_exp(CMD_SHOW, HOME_POS, HOME_POS, GLYPH_CURSOR, 1'b0, 1'b1);
    add_row(1'b0, CH_SHOW, 1);        // show again still saves the cell
    add_exp(CMD_SHOW, HOME_POS, HOME_POS, GLYPH_CURSOR, 1'b0, 1'b1);
    add_row(1'b0, CH_UP, 0);          // blocked at the top margin
    add_row(1'b0, CH_LEFT, 0);        // blocked at the left margin
    add_row(1'b0, 8'h00, 3);          // lowest byte is printable
    add_exp(CMD_RESTORE, 16'd4, 16'd4, 8'd0, 1'b0, 1'b0);
    add_exp(CMD_DRAW, 16'd4, 16'd4, 8'h00, 1'b0, 1'b0);
    add_exp(CMD_SHOW, 16'd14, 16'd4, GLYPH_CURSOR, 1'b0, 1'b1);
    add_row(1'b0, 8'hFF, 3);          // highest byte
    add_exp(CMD_RESTORE, 16'd14, 16'd4, 8'd0, 1'b0, 1'b0);
    add_exp(CMD_DRAW, 16'd14, 16'd4, 8'hFF, 1'b0, 1'b0);
    add_exp(CMD_SHOW, 16'd24, 16'd4, GLYPH_CURSOR, 1'b0, 1'b1);
    add_row(1'b0, CH_BACKSPACE, -1);  // five commands
    add_row(1'b0, CH_NEWLINE, -1);
    add_row(1'b0, CH_DOWN, -1);
    add_row(1'b0, CH_RIGHT, -1);
    add_row(1'b0, CH_UP, -1);
    add_row(1'b0, CH_LEFT, -1);
    add_row(1'b0, CH_CLEAR, -1);
    add_row(1'b0, CH_BACKSPACE, 3);   // at the left margin: cell still blanked
    add_exp(CMD_RESTORE, HOME_POS, HOME_POS, 8'd0, 1'b0, 1'b0);
    add_exp(CMD_DRAW, HOME_POS, HOME_POS, GLYPH_SPACE, 1'b0, 1'b0);
    add_exp(CMD_SHOW, HOME_POS, HOME_POS, GLYPH_CURSOR, 1'b0, 1'b1);
    // small screen: three columns by two rows
    add_row(1'b1, 8'h00, -1);
    add_row(1'b0, 8'h61, -1);
    add_row(1'b0, 8'h62, -1);
    add_row(1'b0, 8'h63, -1);         // wraps to the next line at the right edge
    add_row(1'b0, CH_RIGHT, -1);
    add_row(1'b0, CH_DOWN, -1);       // blocked on the bottom line
    add_row(1'b0, 8'h64, -1);
    add_row(1'b0, 8'h65, -1);         // bottom right corner: scroll
    add_row(1'b0, CH_NEWLINE, -1);    // newline on the bottom line: scroll
    add_row(1'b0, CH_RIGHT, -1);
    add_row(1'b0, CH_RIGHT, -1);
    add_row(1'b0, CH_RIGHT, -1);      // blocked at the right edge

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, first idle pattern
    foreach (dir_tab[i]) begin
      if (dir_tab[i].retune) begin
        drain();
        load_config(mk_cfg(16'd40, 16'd60, 8'd4, 8'd4, 8'd2, 8'd4));
      end else begin
        send_char(dir_tab[i].code, dir_tab[i].typed, dir_tab[i].n);
      end
    end

    // random part, one geometry per phase
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: cfg_now = mk_cfg(16'd640, 16'd480, 8'd4, 8'd4, 8'd2, 8'd4);
        1: cfg_now = mk_cfg(16'd40, 16'd60, 8'd4, 8'd4, 8'd2, 8'd4);
        2: cfg_now = mk_cfg(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // limits of one pixel, zero margins and gaps: left and up wrap at once
        3: cfg_now = mk_cfg(16'd1, 16'd1, 8'd0, 8'd0, 8'd0, 8'd0);
        4: cfg_now = mk_cfg(16'($urandom_range(20, 200)), 16'($urandom_range(30, 200)),
                            8'($urandom_range(20)), 8'($urandom_range(20)),
                            8'($urandom_range(20)), 8'($urandom_range(20)));
        5: cfg_now = mk_cfg(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 8'($urandom_range(255)));
        // resolution below margin: limits wrap high, right and bottom never block
        default: cfg_now = mk_cfg(16'd100, 16'd100, 8'd255, 8'd255, 8'd0, 8'd0);
      endcase
      load_config(cfg_now);
      // idle patterns: sender light / receiver heavy, swapped, then none
      if (p == 2) begin
        tx_gap_pct <= 83;
        rx_gap_pct <= 37;
      end else if (p == 4) begin
        tx_gap_pct <= 0;
        rx_gap_pct <= 0;
      end
      // long command-side hold-off while characters keep coming
      if (p == 1) hold_reqs <= hold_reqs + 1;
      target = busy_chars + PHASE_CHARS;
      while (busy_chars < target) send_char(pick_char(), 1'b0, 3'd0);
    end

    drain();
    if (mismatches == 0) begin
      $display("text_console_cursor_engine_unit verification clean");
    end else begin
      $display("text_console_cursor_engine_unit verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("text_console_cursor_engine_unit verification failed");
    $finish;
  end

endmodule
